[rtl/core/ivu_pkg.sv]
// ivu_pkg: item types and command codes for the interval union tracker.
// No dependencies; imported by ivu_ctrl and interval_union_tracker.
package ivu_pkg;

	localparam int IN_BITS = 32;
	localparam int RC_BITS = 5;

	localparam logic [1:0] KIND_PAINT = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [IN_BITS-1:0] start_pos;
		logic [IN_BITS-1:0] span_len;
	} ivu_cmd_t;

	typedef struct packed {
		logic               hit;
		logic               full_error;
		logic [RC_BITS-1:0] region_count;
	} ivu_rsp_t;

endpackage

[rtl/core/interval_union_tracker.sv]
// Interval union tracker: start/busy command input, one-cycle strobed result.
// Results cannot be held off by the receiver. A query makes one pass over the
// stored intervals and a paint at most two (one pass to find the merged span,
// one pass to shift table entries), each pass reading the table one entry at a
// time through its single read port; a clear or an empty paint makes no pass.
// The result strobe comes the cycle busy falls. Depends on ivu_pkg, ivu_ctrl,
// ivu_mem.
module interval_union_tracker #(
	parameter int MAX_REGIONS = 16,
	parameter int POS_BITS    = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ivu_pkg::ivu_cmd_t cmd,
	output logic              done,
	output ivu_pkg::ivu_rsp_t rsp
);
	import ivu_pkg::*;

	localparam int AW = $clog2(MAX_REGIONS);

	logic               rd_en, wr_en;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [2*POS_BITS-1:0] rd_data, wr_data;

	ivu_ctrl #(
		.MAX_REGIONS(MAX_REGIONS),
		.POS_BITS(POS_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp),
		.mem_rd_en(rd_en),
		.mem_rd_addr(rd_addr),
		.mem_rd_data(rd_data),
		.mem_wr_en(wr_en),
		.mem_wr_addr(wr_addr),
		.mem_wr_data(wr_data)
	);

	ivu_mem #(
		.DEPTH(MAX_REGIONS),
		.WIDTH(2*POS_BITS)
	) u_mem (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule

[rtl/core/ivu_mem.sv]
// ivu_mem: interval table storage, one write port and one registered read port.
// Standalone; instantiated by interval_union_tracker.
module ivu_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/ivu_ctrl.sv]
// ivu_ctrl: sequencer for paint, query and clear items over the interval table.
// Depends on ivu_pkg; drives the ports of ivu_mem.
module ivu_ctrl #(
	parameter int MAX_REGIONS = 16,
	parameter int POS_BITS    = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  ivu_pkg::ivu_cmd_t                    cmd,
	output logic                                 done,
	output ivu_pkg::ivu_rsp_t                    rsp,
	output logic                                 mem_rd_en,
	output logic [$clog2(MAX_REGIONS)-1:0]       mem_rd_addr,
	input  logic [2*POS_BITS-1:0]                mem_rd_data,
	output logic                                 mem_wr_en,
	output logic [$clog2(MAX_REGIONS)-1:0]       mem_wr_addr,
	output logic [2*POS_BITS-1:0]                mem_wr_data
);
	import ivu_pkg::*;

	localparam int AW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int PW = POS_BITS;
	localparam int QW = ((PW > IN_BITS) ? PW : IN_BITS) + 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_REGIONS);
	localparam logic [QW-1:0] POS_MAX_W = {{(QW-PW){1'b0}}, {PW{1'b1}}};

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PREP   = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_DECIDE = 7'b0001000,
		ST_MOVE   = 7'b0010000,
		ST_PUT    = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [1:0]      kind_q;
	logic [PW-1:0]   s_q, e_q;
	logic [IN_BITS-1:0] len_q;
	logic [QW-1:0]   qe_q;
	logic [CW-1:0]   cnt_q, cnt_new_q, rd_q, rem_q, k_q, ins_q, off_q;
	logic            ins_found_q, hit_q, err_q, up_q, move_after_q, done_q;
	logic [AW-1:0]   first_q, put_q, idx_s1;
	logic            vld_s1;

	logic [QW-1:0]   start_w, start_sat, sum_w, end_sat;
	logic [PW-1:0]   rb, rf;
	logic            issue;
	logic [CW-1:0]   wr_idx, rem_dn;
	logic [CW+RC_BITS-1:0] cnt_ext;

	assign start_w   = QW'(cmd.start_pos);
	assign start_sat = (start_w > POS_MAX_W) ? POS_MAX_W : start_w;
	assign sum_w     = {{(QW-PW){1'b0}}, s_q} + QW'(len_q);
	assign end_sat   = (sum_w > POS_MAX_W) ? POS_MAX_W : sum_w;
	assign rb        = mem_rd_data[2*PW-1:PW];
	assign rf        = mem_rd_data[PW-1:0];
	assign rem_dn    = cnt_q - CW'(first_q) - k_q;
	assign wr_idx    = up_q ? (CW'(idx_s1) + CW'(1)) : (CW'(idx_s1) - off_q);

	always_comb begin
		issue = 1'b0;
		case (state_q)
			ST_SCAN: issue = (rd_q != cnt_q);
			ST_MOVE: issue = (rem_q != '0);
			default: issue = 1'b0;
		endcase
	end

	assign mem_rd_en   = issue;
	assign mem_rd_addr = rd_q[AW-1:0];

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = put_q;
		mem_wr_data = {s_q, e_q};
		case (state_q)
			ST_PUT: mem_wr_en = 1'b1;
			ST_MOVE: begin
				mem_wr_en   = vld_s1;
				mem_wr_addr = wr_idx[AW-1:0];
				mem_wr_data = mem_rd_data;
			end
			default: mem_wr_en = 1'b0;
		endcase
	end

	// payload-style registers: no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_q <= cmd.kind;
					s_q    <= start_sat[PW-1:0];
					len_q  <= cmd.span_len;
				end
			end
			ST_PREP: begin
				e_q         <= end_sat[PW-1:0];
				qe_q        <= sum_w;
				rd_q        <= '0;
				k_q         <= '0;
				ins_q       <= cnt_q;
				ins_found_q <= 1'b0;
				first_q     <= '0;
			end
			ST_SCAN: begin
				if (issue) begin
					rd_q   <= rd_q + CW'(1);
					idx_s1 <= rd_q[AW-1:0];
				end
				if (vld_s1 && kind_q == KIND_PAINT) begin
					// merge uses the union grown so far, entries arrive in order
					if (rf >= s_q && rb <= e_q) begin
						if (rb < s_q) s_q <= rb;
						if (rf > e_q) e_q <= rf;
						if (k_q == '0) first_q <= idx_s1;
						k_q <= k_q + CW'(1);
					end else if (!ins_found_q && rb > e_q) begin
						ins_found_q <= 1'b1;
						ins_q       <= CW'(idx_s1);
					end
				end
			end
			ST_DECIDE: begin
				move_after_q <= 1'b0;
				if (k_q == '0) begin
					put_q <= ins_q[AW-1:0];
					up_q  <= 1'b1;
					rd_q  <= cnt_q - CW'(1);
					rem_q <= cnt_q - ins_q;
				end else begin
					put_q        <= first_q;
					up_q         <= 1'b0;
					off_q        <= k_q - CW'(1);
					rd_q         <= CW'(first_q) + k_q;
					rem_q        <= rem_dn;
					move_after_q <= (k_q >= CW'(2)) && (rem_dn != '0);
				end
			end
			ST_MOVE: begin
				if (issue) begin
					idx_s1 <= rd_q[AW-1:0];
					rem_q  <= rem_q - CW'(1);
					rd_q   <= up_q ? (rd_q - CW'(1)) : (rd_q + CW'(1));
				end
			end
			ST_PUT: move_after_q <= 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			cnt_new_q <= '0;
			vld_s1    <= 1'b0;
			hit_q     <= 1'b0;
			err_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_PREP;
				end
				ST_PREP: begin
					hit_q     <= 1'b0;
					err_q     <= 1'b0;
					vld_s1    <= 1'b0;
					cnt_new_q <= cnt_q;
					case (kind_q)
						KIND_PAINT: state_q <= (end_sat <= {{(QW-PW){1'b0}}, s_q}) ?
							ST_FIN : ST_SCAN;
						KIND_QUERY: state_q <= ST_SCAN;
						KIND_CLEAR: begin
							cnt_new_q <= '0;
							state_q   <= ST_FIN;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_SCAN: begin
					vld_s1 <= issue;
					if (vld_s1 && kind_q == KIND_QUERY) begin
						if ((rb <= s_q && rf > s_q) ||
						    (rb > s_q && QW'(rb) < qe_q)) hit_q <= 1'b1;
					end
					if (!issue && !vld_s1) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (kind_q != KIND_PAINT) begin
						state_q <= ST_FIN;
					end else if (k_q == '0) begin
						if (cnt_q >= MAX_C) begin
							err_q   <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							cnt_new_q <= cnt_q + CW'(1);
							state_q   <= (ins_q != cnt_q) ? ST_MOVE : ST_PUT;
						end
					end else begin
						cnt_new_q <= cnt_q - k_q + CW'(1);
						state_q   <= ST_PUT;
					end
				end
				ST_MOVE: begin
					vld_s1 <= issue;
					if (!issue && !vld_s1) state_q <= up_q ? ST_PUT : ST_FIN;
				end
				ST_PUT: state_q <= move_after_q ? ST_MOVE : ST_FIN;
				ST_FIN: begin
					cnt_q   <= cnt_new_q;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cnt_ext = {{RC_BITS{1'b0}}, cnt_q};

	assign busy             = (state_q != ST_IDLE);
	assign done             = done_q;
	assign rsp.hit          = hit_q;
	assign rsp.full_error   = err_q;
	assign rsp.region_count = cnt_ext[RC_BITS-1:0];

	a_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_C)
		else $error("stored count above table depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
		else $error("table read and write hit the same entry");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done_q))
		else $error("accepted item did not raise busy");

endmodule

[tb/sv/tb_interval_union_tracker.sv]
// Testbench for interval_union_tracker: directed and random paint/query/clear items,
// checked against an in-bench interval table predictor. Depends on ivu_pkg and the RTL.
module tb_interval_union_tracker;
	timeunit 1ns;
	timeprecision 1ps;
	import ivu_pkg::*;

	localparam int NREG = 16;
	localparam logic [31:0] PMAX = 32'hFFFF_FFFF;
	localparam int STALL_LIMIT = 2000;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	ivu_cmd_t cmd = '0;
	ivu_rsp_t rsp;

	interval_union_tracker DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// predictor state
	logic [31:0] tab_lo[NREG];
	logic [31:0] tab_hi[NREG];
	int tab_n = 0;
	ivu_rsp_t pending_rsp[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit allow_gaps = 1'b1;

	function automatic ivu_rsp_t predict_item(ivu_cmd_t c);
		ivu_rsp_t r;
		logic [32:0] s, e, b, f, qe;
		logic [31:0] nlo[NREG];
		logic [31:0] nhi[NREG];
		int n, absorbed;
		bit placed;
		r = '0;
		s = {1'b0, c.start_pos};
		case (c.kind)
			KIND_PAINT: begin
				e = s + c.span_len;
				if (e > PMAX) e = PMAX;
				if (e > s) begin
					absorbed = 0;
					for (int i = 0; i < tab_n; i++) begin
						b = tab_lo[i]; f = tab_hi[i];
						if (f >= s && b <= e) begin
							if (b < s) s = b;
							if (f > e) e = f;
							absorbed++;
						end
					end
					if (absorbed == 0 && tab_n >= NREG) r.full_error = 1'b1;
					else begin
						n = 0; placed = 1'b0;
						for (int i = 0; i < tab_n; i++) begin
							b = tab_lo[i]; f = tab_hi[i];
							if (!(f >= s && b <= e)) begin
								if (!placed && b > e) begin
									nlo[n] = s[31:0]; nhi[n] = e[31:0]; n++;
									placed = 1'b1;
								end
								if (n < NREG) begin
									nlo[n] = b[31:0]; nhi[n] = f[31:0]; n++;
								end
							end
						end
						if (!placed && n < NREG) begin
							nlo[n] = s[31:0]; nhi[n] = e[31:0]; n++;
						end
						for (int i = 0; i < n; i++) begin
							tab_lo[i] = nlo[i]; tab_hi[i] = nhi[i];
						end
						tab_n = n;
					end
				end
			end
			KIND_QUERY: begin
				qe = s + c.span_len;
				for (int i = 0; i < tab_n; i++) begin
					b = tab_lo[i]; f = tab_hi[i];
					if ((b <= s && f > s) || (b > s && b < qe)) r.hit = 1'b1;
				end
			end
			KIND_CLEAR: tab_n = 0;
			default: ;
		endcase
		r.region_count = tab_n[4:0];
		return r;
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// start stays high between back-to-back items; it drops for a gap or to drain
	task automatic send_item(logic [1:0] k, logic [31:0] sp, logic [31:0] ln);
		ivu_cmd_t c;
		c.kind = k; c.start_pos = sp; c.span_len = ln;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			idle_cycles($urandom_range(1, 14));
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_rsp = {pending_rsp, predict_item(c)};
	endtask

	always @(posedge clk) begin
		ivu_rsp_t x;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected result: actual %p", $time, rsp);
				errors++;
			end else begin
				x = pending_rsp.pop_front();
				if (rsp.hit !== x.hit || rsp.full_error !== x.full_error ||
				    rsp.region_count !== x.region_count) begin
					$display("%0t mismatch: expected %p actual %p", $time, x, rsp);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with neither an accepted item nor a result
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_interval_union_tracker failed");
			$finish;
		end
	end

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		idle_cycles(4);
	endtask

	task automatic test_directed();
		send_item(KIND_QUERY, 0, PMAX);          // empty table
		send_item(KIND_PAINT, 100, 0);           // empty paint
		send_item(KIND_PAINT, 100, 50);
		send_item(KIND_PAINT, 150, 10);          // touches end
		send_item(KIND_PAINT, 90, 10);           // touches begin
		send_item(KIND_PAINT, 90, 5);            // same start
		send_item(KIND_QUERY, 159, 0);
		send_item(KIND_QUERY, 160, 1);
		send_item(KIND_QUERY, 80, 11);
		send_item(KIND_QUERY, 80, 10);
		send_item(KIND_PAINT, PMAX, 5);          // saturated, empty
		send_item(KIND_PAINT, PMAX - 3, PMAX);   // end saturates
		send_item(KIND_QUERY, PMAX, PMAX);
		send_item(KIND_PAINT, 0, 1);
		send_item(KIND_SPARE, 0, 0);             // unused kind
		send_item(KIND_CLEAR, PMAX, PMAX);
		for (int i = 0; i < 17; i++) send_item(KIND_PAINT, i * 10, 5);
		send_item(KIND_PAINT, 7, 1);             // absorbs none, full
		send_item(KIND_PAINT, 5, 5);             // merges while full
		send_item(KIND_PAINT, 0, PMAX);
		wait_drained();                          // sender pause until all results in
	endtask

	task automatic test_random(int count);
		logic [1:0] k;
		logic [31:0] sp, ln;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) k = KIND_PAINT;
			else if (r < 93) k = KIND_QUERY;
			else if (r < 97) k = KIND_CLEAR;
			else k = KIND_SPARE;
			// mostly a small window so intervals collide; sometimes full range
			if ($urandom_range(0, 9) == 0) begin
				sp = $urandom(); ln = $urandom();
			end else begin
				sp = $urandom_range(0, 400);
				if ($urandom_range(0, 19) == 0) sp = PMAX - sp;
				ln = $urandom_range(0, 12);
			end
			send_item(k, sp, ln);
		end
	endtask

	initial begin
		idle_cycles(10);
		arst_n <= 1'b1;
		idle_cycles(2);
		test_directed();
		test_random(1200);
		allow_gaps = 1'b0;
		test_random(400);
		wait_drained();
		idle_cycles(50);
		if (errors == 0) $display("tb_interval_union_tracker passed");
		else $display("tb_interval_union_tracker failed");
		$finish;
	end
endmodule
